// File: design/ordered_list_engine_macros.svh
// Assertion helpers used by the list engine datapath.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ole_pkg.sv
package ole_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 4;
    localparam int FIELD_W        = 32;
    localparam int OCC_W          = 5;
    localparam int STATUS_W       = 2;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_INSERT_AFTER = 4'd5;
    localparam logic [KIND_W-1:0] KIND_REVERSE     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SEARCH      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_COUNT       = 4'd8;
    localparam logic [KIND_W-1:0] KIND_DUMP        = 4'd9;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_ALIGN,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MATCH,
        OP_INSERT,
        OP_REMOVE,
        OP_FLIP,
        OP_SHIFT
    } t_op;

    typedef enum logic [2:0] {
        POS_FRONT,
        POS_BACK_INS,
        POS_BACK_REM,
        POS_MATCH,
        POS_AFTER_MATCH,
        POS_SCAN
    } t_pos;

    typedef struct packed {
        logic                load;
        t_op                 op;
        t_pos                pos;
        logic                key_anchor;
        logic                align_load;
        logic                align_dec;
        logic                scan_clr;
        logic                scan_inc;
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic                data_read;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              short_list;
        logic              match_any;
        logic              align_zero;
        logic              scan_last;
        logic              out_free;
    } t_dp_status;

endpackage

// File: design/ole_ctrl.sv
module ole_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  ole_pkg::t_dp_status    i_status,
    output ole_pkg::t_ctrl_cmd     o_cmd
);
    import ole_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.op         = OP_NONE;
        o_cmd.pos        = POS_FRONT;
        o_cmd.key_anchor = 1'b0;
        o_cmd.align_load = 1'b0;
        o_cmd.align_dec  = 1'b0;
        o_cmd.scan_clr   = 1'b0;
        o_cmd.scan_inc   = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.status     = ST_OK;
        o_cmd.last       = 1'b1;
        o_cmd.data_read  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (i_status.kind)
                    KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                            if (i_status.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.op  = OP_INSERT;
                                o_cmd.pos = (i_status.kind == KIND_PUSH_FRONT) ?
                                            POS_FRONT : POS_BACK_INS;
                            end
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK: begin
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                            if (i_status.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op        = OP_REMOVE;
                                o_cmd.data_read = 1'b1;
                                o_cmd.pos = (i_status.kind == KIND_POP_FRONT) ?
                                            POS_FRONT : POS_BACK_REM;
                            end
                        end
                    end
                    KIND_DELETE, KIND_SEARCH: begin
                        if (i_status.empty) begin
                            if (i_status.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = (i_status.kind == KIND_DELETE) ?
                                               ST_EMPTY : ST_MISSING;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            o_cmd.op = OP_MATCH;
                            n_state  = S_FIND;
                        end
                    end
                    KIND_INSERT_AFTER: begin
                        if (i_status.empty || i_status.full) begin
                            if (i_status.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = i_status.empty ? ST_EMPTY : ST_FULL;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            o_cmd.op         = OP_MATCH;
                            o_cmd.key_anchor = 1'b1;
                            n_state          = S_FIND;
                        end
                    end
                    KIND_REVERSE: begin
                        if (i_status.short_list) begin
                            if (i_status.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.op         = OP_FLIP;
                            o_cmd.align_load = 1'b1;
                            n_state          = S_ALIGN;
                        end
                    end
                    KIND_DUMP: begin
                        if (i_status.empty) begin
                            if (i_status.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_EMPTY;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_DUMP;
                        end
                    end
                    default: begin
                        // Count and the unused codes report the occupancy only.
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end

            S_FIND: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (!i_status.match_any) begin
                        o_cmd.status = ST_MISSING;
                    end else if (i_status.kind == KIND_DELETE) begin
                        o_cmd.op  = OP_REMOVE;
                        o_cmd.pos = POS_MATCH;
                    end else if (i_status.kind == KIND_INSERT_AFTER) begin
                        o_cmd.op  = OP_INSERT;
                        o_cmd.pos = POS_AFTER_MATCH;
                    end
                end
            end

            S_ALIGN: begin
                if (!i_status.align_zero) begin
                    o_cmd.op        = OP_SHIFT;
                    o_cmd.align_dec = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            S_DUMP: begin
                o_cmd.pos = POS_SCAN;
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.data_read = 1'b1;
                    o_cmd.last      = i_status.scan_last;
                    o_cmd.scan_inc  = 1'b1;
                    if (i_status.scan_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/ole_dp.sv
`include "ordered_list_engine_macros.svh"

module ole_dp #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ole_pkg::t_ctrl_cmd                 i_cmd,
    output ole_pkg::t_dp_status                o_status,
    input  logic        [ole_pkg::KIND_W-1:0]  i_kind,
    input  logic signed [ole_pkg::FIELD_W-1:0] i_value,
    input  logic signed [ole_pkg::FIELD_W-1:0] i_anchor,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ole_pkg::FIELD_W-1:0] o_data,
    output logic        [ole_pkg::OCC_W-1:0]   o_occupancy,
    output logic        [ole_pkg::STATUS_W-1:0] o_status_code,
    output logic                               o_last
);
    import ole_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] r_cells [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cells [CAPACITY];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CAPACITY-1:0]   r_match;
    logic [KIND_W-1:0]     r_kind;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] r_anchor;
    logic [IW-1:0]         r_scan;
    logic [CW-1:0]         r_align;
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_data;
    logic [OCC_W-1:0]      r_occ;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_last;

    logic [DATA_WIDTH-1:0] value_dw;
    logic [DATA_WIDTH-1:0] anchor_dw;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] read_data;
    logic [FIELD_W-1:0]    read_field;
    logic [IW-1:0]         first_idx;
    logic [IW-1:0]         pos;

    // Values are held at DATA_WIDTH bits; results show them zero-extended
    // or cut down to the field width.
    generate
        if (DATA_WIDTH <= FIELD_W) begin : g_narrow
            assign value_dw   = i_value[DATA_WIDTH-1:0];
            assign anchor_dw  = i_anchor[DATA_WIDTH-1:0];
            assign read_field = FIELD_W'(read_data);
        end else begin : g_wide
            assign value_dw   = DATA_WIDTH'(i_value);
            assign anchor_dw  = DATA_WIDTH'(i_anchor);
            assign read_field = read_data[FIELD_W-1:0];
        end
    endgenerate

    assign key = i_cmd.key_anchor ? r_anchor : r_value;

    always_comb begin
        first_idx = '0;
        for (int j = CAPACITY - 1; j >= 0; j--) begin
            if (r_match[j]) begin
                first_idx = IW'(j);
            end
        end
    end

    always_comb begin
        case (i_cmd.pos)
            POS_FRONT:       pos = '0;
            POS_BACK_INS:    pos = r_count[IW-1:0];
            POS_BACK_REM:    pos = IW'(r_count - 1'b1);
            POS_MATCH:       pos = first_idx;
            POS_AFTER_MATCH: pos = IW'(first_idx + 1'b1);
            POS_SCAN:        pos = r_scan;
            default:         pos = '0;
        endcase
    end

    assign read_data = r_cells[pos];

    // Cell array next state: every cell takes its own, a neighbor, the
    // mirrored cell or the new value, so each step moves all cells together.
    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        case (i_cmd.op)
            OP_INSERT: begin
                for (int j = 1; j < CAPACITY; j++) begin
                    if (IW'(j) > pos) begin
                        n_cells[j] = r_cells[j-1];
                    end
                end
                n_cells[pos] = r_value;
                n_count      = r_count + 1'b1;
            end
            OP_REMOVE: begin
                for (int j = 0; j < CAPACITY - 1; j++) begin
                    if (IW'(j) >= pos) begin
                        n_cells[j] = r_cells[j+1];
                    end
                end
                n_count = r_count - 1'b1;
            end
            OP_FLIP: begin
                for (int j = 0; j < CAPACITY; j++) begin
                    n_cells[j] = r_cells[CAPACITY-1-j];
                end
            end
            OP_SHIFT: begin
                for (int j = 0; j < CAPACITY - 1; j++) begin
                    n_cells[j] = r_cells[j+1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_value  <= value_dw;
            r_anchor <= anchor_dw;
        end
        if (i_cmd.op == OP_MATCH) begin
            for (int j = 0; j < CAPACITY; j++) begin
                r_match[j] <= (r_cells[j] == key) && (CW'(j) < r_count);
            end
        end
        if (i_cmd.emit) begin
            r_data   <= i_cmd.data_read ? read_field : '0;
            r_occ    <= OCC_W'(n_count);
            r_status <= i_cmd.status;
            r_last   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_align     <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.align_load) begin
                r_align <= CW'(CAPACITY) - r_count;
            end else if (i_cmd.align_dec) begin
                r_align <= r_align - 1'b1;
            end
        end
    end

    assign o_status.kind       = r_kind;
    assign o_status.empty      = (r_count == '0);
    assign o_status.full       = (r_count == CW'(CAPACITY));
    assign o_status.short_list = (r_count <= CW'(1));
    assign o_status.match_any  = |r_match;
    assign o_status.align_zero = (r_align == '0);
    assign o_status.scan_last  = (CW'(r_scan) == r_count - 1'b1);
    assign o_status.out_free   = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_data        = r_data;
    assign o_occupancy   = r_occ;
    assign o_status_code = r_status;
    assign o_last        = r_last;

    `OLE_ASSERT_SAME(a_insert_room, i_clk, i_rst_n, i_cmd.op == OP_INSERT, r_count < CW'(CAPACITY), "insert into a full list")
    `OLE_ASSERT_SAME(a_remove_held, i_clk, i_rst_n, i_cmd.op == OP_REMOVE, r_count != '0, "remove from an empty list")
    `OLE_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n, i_cmd.op == OP_INSERT, r_count == $past(r_count) + 1'b1, "insert did not grow the list")
    `OLE_ASSERT_SAME(a_emit_slot, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_ready, "result overwrote an untaken beat")

endmodule

// File: design/ordered_list_engine.sv
// Bounded ordered list engine with push and pop at both ends, delete by
// value, insert after an anchor value, reverse, search, count and dump.
// Input channel: i_valid / o_ready carry one command beat (i_kind, i_value,
// i_anchor). Output channel: o_valid / i_ready carry result beats (o_data,
// o_occupancy, o_status, o_last). Every command yields one result beat,
// except dump, which yields one beat per held entry, front to back, with
// o_last on the final one (an empty list dumps a single beat).
// Push, pop and count write their result from the execute state; delete,
// insert_after and search first register the match vector of all cells,
// then act on the first hit; reverse leaves a list of up to one entry as
// it is, else mirrors the cell row, then a shift realigns the mirrored
// row one place per cycle; dump writes one beat per entry from its scan.
// Commands are taken one at a time: o_ready is high while the controller is
// idle, from the cycle after a command's last result is registered.
// A receiver stall holds the output register, and the controller holds any
// step that writes a result until it is free, so no beat is lost or repeated.
// Reset (synchronous, active low) empties the list and drops o_valid; the
// cell contents are not cleared, since only held entries are ever read.
module ordered_list_engine #(
    parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic        [ole_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [ole_pkg::FIELD_W-1:0]  i_value,
    input  logic signed [ole_pkg::FIELD_W-1:0]  i_anchor,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ole_pkg::FIELD_W-1:0]  o_data,
    output logic        [ole_pkg::OCC_W-1:0]    o_occupancy,
    output logic        [ole_pkg::STATUS_W-1:0] o_status,
    output logic                                o_last
);
    import ole_pkg::*;

    // Commands flow from the controller; flags about the list flow back.
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    ole_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (dp_status),
        .o_cmd    (ctrl_cmd)
    );

    // The datapath holds the cell row, match vector, counters and the
    // output register that decouples the two channels.
    ole_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_status      (dp_status),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_anchor      (i_anchor),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data),
        .o_occupancy   (o_occupancy),
        .o_status_code (o_status),
        .o_last        (o_last)
    );

endmodule
